@@ hdl/pfp_pkg.sv @@
// Shared widths, limits and the queue item type for the plane equation block.
`timescale 1ns / 1ps

package pfp_pkg;

    // Input coordinate and front datapath widths.
    localparam int CW    = 16;
    localparam int DW    = CW + 1;
    localparam int PW    = 2 * DW;
    localparam int MAGW  = PW + 1;
    localparam int POSW  = 6;

    // Normalized normal: the largest magnitude lies in [2^(NW-1), 2^NW).
    localparam int NW    = 20;
    localparam int NSH   = NW - 1;

    // Back datapath widths.
    localparam int SQW   = 2 * NW;
    localparam int QSW   = SQW + 2;
    localparam int DPW   = NW + 1 + CW;
    localparam int DOTW  = DPW + 2;
    localparam int DMW   = DPW;
    localparam int FRAC  = 20;
    localparam int XW    = QSW + FRAC;
    localparam int RW    = XW / 2;
    localparam int TW    = XW + 1;
    localparam int DNW   = RW + 1;
    localparam int DVW   = 55;
    localparam int QW    = 23;

    // Result scaling and saturation.
    localparam int UW      = 16;
    localparam int OW      = 24;
    localparam int UNIT_SH = 24;
    localparam int OFFS_SH = 16;
    localparam logic [QW-1:0] UNIT_MAX = QW'(16384);
    localparam logic [QW-1:0] OFFS_MAX = QW'(4194304);

    // Default queue depth between the front and the back.
    localparam int FIFO_DEPTH = 4;

    // One normalized normal with its first point, as it waits in the queue.
    typedef struct packed {
        logic                 degen;
        logic [2:0]           neg;
        logic [2:0][NW-1:0]   mag;
        logic [2:0][CW-1:0]   p1;
    } t_item;

endpackage

@@ hdl/plane_from_points.sv @@
// Top level of the normalized plane equation block.
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_stall    i_op, i_p1_*, i_p2_*, i_p3_*
//   result   out        o_valid / i_stall    o_unit_n*, o_plane_offset, o_degenerate
//
// One item is accepted per cycle and one result leaves per cycle when nothing stalls.
// A result passes from its input transfer through six front stages, the queue, and
// 60 back stages: operand stages, square root stages, quotient stages and the output
// register.
// Reset is synchronous and active low; it clears only the valid bits and the queue.
// A stall on the result side holds the back; the queue absorbs items until full,
// then the front holds and o_stall rises.
`timescale 1ns / 1ps

module plane_from_points import pfp_pkg::*; #(
    parameter int P_FIFO_DEPTH = FIFO_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_op,
    input  logic signed [CW-1:0] i_p1_x,
    input  logic signed [CW-1:0] i_p1_y,
    input  logic signed [CW-1:0] i_p1_z,
    input  logic signed [CW-1:0] i_p2_x,
    input  logic signed [CW-1:0] i_p2_y,
    input  logic signed [CW-1:0] i_p2_z,
    input  logic signed [CW-1:0] i_p3_x,
    input  logic signed [CW-1:0] i_p3_y,
    input  logic signed [CW-1:0] i_p3_z,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [UW-1:0] o_unit_nx,
    output logic signed [UW-1:0] o_unit_ny,
    output logic signed [UW-1:0] o_unit_nz,
    output logic signed [OW-1:0] o_plane_offset,
    output logic                 o_degenerate
);

    logic  f_valid, f_stall;
    t_item f_item;
    logic  q_valid, q_stall;
    t_item q_item;

    // Front: accept and normalize.
    pfp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_op    (i_op),
        .i_p1_x  (i_p1_x),
        .i_p1_y  (i_p1_y),
        .i_p1_z  (i_p1_z),
        .i_p2_x  (i_p2_x),
        .i_p2_y  (i_p2_y),
        .i_p2_z  (i_p2_z),
        .i_p3_x  (i_p3_x),
        .i_p3_y  (i_p3_y),
        .i_p3_z  (i_p3_z),
        .o_valid (f_valid),
        .o_item  (f_item),
        .i_stall (f_stall)
    );

    // Queue between the two halves.
    pfp_fifo #(
        .DEPTH (P_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_stall (f_stall),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_stall (q_stall),
        .o_item  (q_item)
    );

    // Back: length, division and output register.
    pfp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .o_stall        (q_stall),
        .i_item         (q_item),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_unit_nx      (o_unit_nx),
        .o_unit_ny      (o_unit_ny),
        .o_unit_nz      (o_unit_nz),
        .o_plane_offset (o_plane_offset),
        .o_degenerate   (o_degenerate)
    );

`ifndef SYNTHESIS
    // A degenerate result carries zeros in every other field.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_unit_nx == 0 && o_unit_ny == 0 &&
                                    o_unit_nz == 0 && o_plane_offset == 0)
        else $error("degenerate result with nonzero fields");

    // Unit normal components stay within one in Q1.14.
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_unit_nx <= 16'sd16384 && o_unit_nx >= -16'sd16384 &&
                    o_unit_ny <= 16'sd16384 && o_unit_ny >= -16'sd16384 &&
                    o_unit_nz <= 16'sd16384 && o_unit_nz >= -16'sd16384)
        else $error("unit normal component out of range");

    // The queue keeps an item that the back could not take.
    a_queue_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid && q_stall |=> q_valid)
        else $error("queue dropped a stalled item");

    // The front only stalls the input when the queue is full.
    a_front_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> f_valid && f_stall)
        else $error("input stalled while the queue had room");
`endif

endmodule

@@ hdl/pfp_front.sv @@
// Front pipeline: accepts items, forms the raw normal and normalizes it.
`timescale 1ns / 1ps

module pfp_front import pfp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_op,
    input  logic signed [CW-1:0] i_p1_x,
    input  logic signed [CW-1:0] i_p1_y,
    input  logic signed [CW-1:0] i_p1_z,
    input  logic signed [CW-1:0] i_p2_x,
    input  logic signed [CW-1:0] i_p2_y,
    input  logic signed [CW-1:0] i_p2_z,
    input  logic signed [CW-1:0] i_p3_x,
    input  logic signed [CW-1:0] i_p3_y,
    input  logic signed [CW-1:0] i_p3_z,
    output logic                 o_valid,
    output t_item                o_item,
    input  logic                 i_stall
);

    // Position of the highest set bit; zero for a zero word.
    function automatic logic [POSW-1:0] msb_pos(input logic [MAGW-1:0] v);
        logic [POSW-1:0] p;
        p = '0;
        for (int i = 0; i < MAGW; i++) begin
            if (v[i]) p = POSW'(i);
        end
        return p;
    endfunction

    logic en;
    logic signed [CW-1:0] w_p1 [3];
    logic signed [CW-1:0] w_p2 [3];
    logic signed [CW-1:0] w_p3 [3];

    logic                 r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic                 r_op1, r_op2;
    logic signed [DW-1:0] r_a [3];
    logic signed [DW-1:0] r_b [3];
    logic signed [CW-1:0] r_p1_1 [3], r_p1_2 [3], r_p1_3 [3], r_p1_4 [3], r_p1_5 [3];
    logic signed [CW-1:0] r_p2_1 [3], r_p2_2 [3];
    logic signed [PW-1:0] r_pr [6];
    logic signed [MAGW-1:0] r_n [3];
    logic [MAGW-1:0]      r_mag4 [3], r_mag5 [3];
    logic [2:0]           r_neg4, r_neg5;
    logic [MAGW-1:0]      r_or4;
    logic [POSW-1:0]      r_pos5;
    logic                 r_degen5;
    logic [NW-1:0]        w_nm [3];
    t_item                r_item6;

    // The whole front moves together; it holds when its last stage cannot transfer.
    assign en      = !(r_v6 && i_stall);
    assign o_stall = !en;

    assign w_p1[0] = i_p1_x;
    assign w_p1[1] = i_p1_y;
    assign w_p1[2] = i_p1_z;
    assign w_p2[0] = i_p2_x;
    assign w_p2[1] = i_p2_y;
    assign w_p2[2] = i_p2_z;
    assign w_p3[0] = i_p3_x;
    assign w_p3[1] = i_p3_y;
    assign w_p3[2] = i_p3_z;

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // Stage 1: edge vectors from the first point.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op1 <= i_op;
            for (int i = 0; i < 3; i++) begin
                r_a[i]    <= DW'(w_p2[i]) - DW'(w_p1[i]);
                r_b[i]    <= DW'(w_p3[i]) - DW'(w_p1[i]);
                r_p1_1[i] <= w_p1[i];
                r_p2_1[i] <= w_p2[i];
            end
        end
    end

    // Stage 2: the six partial products of the cross product.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op2  <= r_op1;
            r_pr[0] <= r_a[1] * r_b[2];
            r_pr[1] <= r_a[2] * r_b[1];
            r_pr[2] <= r_a[2] * r_b[0];
            r_pr[3] <= r_a[0] * r_b[2];
            r_pr[4] <= r_a[0] * r_b[1];
            r_pr[5] <= r_a[1] * r_b[0];
            r_p1_2 <= r_p1_1;
            r_p2_2 <= r_p2_1;
        end
    end

    // Stage 3: raw normal, either the cross product or the given vector.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_n[i] <= r_op2 ? MAGW'(r_p2_2[i])
                                : MAGW'(r_pr[2*i]) - MAGW'(r_pr[2*i+1]);
            end
            r_p1_3 <= r_p1_2;
        end
    end

    // Stage 4: sign and magnitude, and the OR of the magnitudes for the leading one.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_neg4[i] <= r_n[i][MAGW-1];
                r_mag4[i] <= r_n[i][MAGW-1] ? MAGW'(-r_n[i]) : MAGW'(r_n[i]);
            end
            r_or4  <= (r_n[0][MAGW-1] ? MAGW'(-r_n[0]) : MAGW'(r_n[0]))
                    | (r_n[1][MAGW-1] ? MAGW'(-r_n[1]) : MAGW'(r_n[1]))
                    | (r_n[2][MAGW-1] ? MAGW'(-r_n[2]) : MAGW'(r_n[2]));
            r_p1_4 <= r_p1_3;
        end
    end

    // Stage 5: leading one of the largest magnitude; a zero word is degenerate.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pos5   <= msb_pos(r_or4);
            r_degen5 <= (r_or4 == '0);
            r_mag5   <= r_mag4;
            r_neg5   <= r_neg4;
            r_p1_5   <= r_p1_4;
        end
    end

    // Shift all three magnitudes by the same amount; right shifts truncate.
    always_comb begin
        logic [MAGW-1:0] shr;
        logic [MAGW-1:0] shl;
        for (int i = 0; i < 3; i++) begin
            shr     = r_mag5[i] >> (r_pos5 - POSW'(NSH));
            shl     = r_mag5[i] << (POSW'(NSH) - r_pos5);
            w_nm[i] = (r_pos5 >= POSW'(NSH)) ? shr[NW-1:0] : shl[NW-1:0];
        end
    end

    // Stage 6: the normalized item, offered to the queue.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_item6.degen <= r_degen5;
            r_item6.neg   <= r_neg5;
            for (int i = 0; i < 3; i++) begin
                r_item6.mag[i] <= w_nm[i];
                r_item6.p1[i]  <= r_p1_5[i];
            end
        end
    end

    assign o_valid = r_v6;
    assign o_item  = r_item6;

endmodule

@@ hdl/pfp_fifo.sv @@
// Short queue that decouples the front pipeline from the back pipeline.
`timescale 1ns / 1ps

module pfp_fifo import pfp_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_stall,
    output t_item o_item
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [CNW-1:0] r_cnt;
    logic           push, pop;

    assign o_stall = (r_cnt == CNW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;
    assign o_item  = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (pop)  r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + CNW'(push) - CNW'(pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_item;
    end

endmodule

@@ hdl/pfp_back.sv @@
// Back pipeline: length by a pipelined square root, then rounded quotients.
`timescale 1ns / 1ps

module pfp_back import pfp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_item                i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [UW-1:0] o_unit_nx,
    output logic signed [UW-1:0] o_unit_ny,
    output logic signed [UW-1:0] o_unit_nz,
    output logic signed [OW-1:0] o_plane_offset,
    output logic                 o_degenerate
);

    logic en;

    // Front stages of the back.
    logic                  r_v0, r_v1, r_v2;
    t_item                 r_it0, r_it1, r_it2;
    logic [SQW-1:0]        r_sq1 [3];
    logic signed [DPW-1:0] r_pd1 [3];
    logic [QSW-1:0]        r_q2;
    logic signed [DOTW-1:0] r_dot2;
    logic signed [NW:0]    w_np [3];

    // Root stages.
    logic                  r_sv   [RW+1];
    logic [XW-1:0]         r_srem [RW+1];
    logic [RW-1:0]         r_sroot[RW+1];
    t_item                 r_sit  [RW+1];
    logic                  r_sdn  [RW+1];
    logic [DMW-1:0]        r_sdm  [RW+1];

    // Quotient stages: lanes 0 to 2 are the normal, lane 3 is the offset.
    logic                  r_dv   [QW+1];
    logic [DVW-1:0]        r_drem [QW+1][4];
    logic [QW-1:0]         r_dq   [QW+1][4];
    logic [DNW-1:0]        r_dd   [QW+1];
    logic [2:0]            r_dneg [QW+1];
    logic                  r_ddn  [QW+1];
    logic                  r_ddg  [QW+1];

    // Output register.
    logic                  r_ov;
    logic signed [UW-1:0]  r_u [3];
    logic signed [OW-1:0]  r_off;
    logic                  r_deg;
    logic signed [UW-1:0]  w_u [3];
    logic signed [OW-1:0]  w_off;

    // The back moves whenever the output register is free or being taken.
    assign en      = !r_ov || !i_stall;
    assign o_stall = !en;

    // Signed normal components for the dot product.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_np[i] = r_it0.neg[i] ? -$signed({1'b0, r_it0.mag[i]})
                                   : $signed({1'b0, r_it0.mag[i]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_sv[0] <= 1'b0;
        end else if (en) begin
            r_v0    <= i_valid;
            r_v1    <= r_v0;
            r_v2    <= r_v1;
            r_sv[0] <= r_v2;
        end
    end

    // Queue transfer, squares and dot terms, sums, then the root operand.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it0 <= i_item;
            for (int i = 0; i < 3; i++) begin
                r_sq1[i] <= SQW'(r_it0.mag[i]) * SQW'(r_it0.mag[i]);
                r_pd1[i] <= DPW'(w_np[i]) * DPW'($signed(r_it0.p1[i]));
            end
            r_it1  <= r_it0;
            r_q2   <= QSW'(r_sq1[0]) + QSW'(r_sq1[1]) + QSW'(r_sq1[2]);
            r_dot2 <= DOTW'(r_pd1[0]) + DOTW'(r_pd1[1]) + DOTW'(r_pd1[2]);
            r_it2  <= r_it1;
            r_srem[0]  <= {r_q2, {FRAC{1'b0}}};
            r_sroot[0] <= '0;
            r_sit[0]   <= r_it2;
            // The offset is minus the dot product.
            r_sdn[0]   <= (r_dot2 > 0);
            r_sdm[0]   <= r_dot2[DOTW-1] ? DMW'(-r_dot2) : DMW'(r_dot2);
        end
    end

    // Square root, one result bit per stage, most significant first.
    for (genvar j = 0; j < RW; j++) begin : g_sqrt
        localparam int K = RW - 1 - j;
        logic [TW-1:0] w_t;
        logic          w_ge;
        assign w_t  = (TW'(r_sroot[j]) << (K + 1)) + (TW'(1) << (2 * K));
        assign w_ge = (TW'(r_srem[j]) >= w_t);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[j+1] <= 1'b0;
            end else if (en) begin
                r_sv[j+1] <= r_sv[j];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_srem[j+1]  <= w_ge ? r_srem[j] - w_t[XW-1:0] : r_srem[j];
                r_sroot[j+1] <= w_ge ? (r_sroot[j] | (RW'(1) << K)) : r_sroot[j];
                r_sit[j+1]   <= r_sit[j];
                r_sdn[j+1]   <= r_sdn[j];
                r_sdm[j+1]   <= r_sdm[j];
            end
        end
    end

    // Dividend and divisor for round-half-away division: (2n + r) / (2r).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_sv[RW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r_drem[0][l] <= (DVW'(r_sit[RW].mag[l]) << (UNIT_SH + 1))
                              + DVW'(r_sroot[RW]);
                r_dq[0][l]   <= '0;
            end
            r_drem[0][3] <= (DVW'(r_sdm[RW]) << (OFFS_SH + 1)) + DVW'(r_sroot[RW]);
            r_dq[0][3]   <= '0;
            r_dd[0]      <= {r_sroot[RW], 1'b0};
            r_dneg[0]    <= r_sit[RW].neg;
            r_ddn[0]     <= r_sdn[RW];
            r_ddg[0]     <= r_sit[RW].degen;
        end
    end

    // Restoring division, one quotient bit per stage in all four lanes.
    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int K = QW - 1 - j;
        logic [DVW-1:0] w_dsh;
        assign w_dsh = DVW'(r_dd[j]) << K;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1] <= 1'b0;
            end else if (en) begin
                r_dv[j+1] <= r_dv[j];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int l = 0; l < 4; l++) begin
                    if (r_drem[j][l] >= w_dsh) begin
                        r_drem[j+1][l] <= r_drem[j][l] - w_dsh;
                        r_dq[j+1][l]   <= r_dq[j][l] | (QW'(1) << K);
                    end else begin
                        r_drem[j+1][l] <= r_drem[j][l];
                        r_dq[j+1][l]   <= r_dq[j][l];
                    end
                end
                r_dd[j+1]   <= r_dd[j];
                r_dneg[j+1] <= r_dneg[j];
                r_ddn[j+1]  <= r_ddn[j];
                r_ddg[j+1]  <= r_ddg[j];
            end
        end
    end

    // Saturate, apply the sign, and force zeros for a degenerate normal.
    always_comb begin
        logic [QW-1:0] cu;
        logic [QW-1:0] co;
        for (int l = 0; l < 3; l++) begin
            cu     = (r_dq[QW][l] > UNIT_MAX) ? UNIT_MAX : r_dq[QW][l];
            w_u[l] = r_ddg[QW] ? '0
                   : (r_dneg[QW][l] ? -$signed(UW'(cu)) : $signed(UW'(cu)));
        end
        co    = (r_dq[QW][3] > OFFS_MAX) ? OFFS_MAX : r_dq[QW][3];
        w_off = r_ddg[QW] ? '0 : (r_ddn[QW] ? -$signed(OW'(co)) : $signed(OW'(co)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_dv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u   <= w_u;
            r_off <= w_off;
            r_deg <= r_ddg[QW];
        end
    end

    assign o_valid        = r_ov;
    assign o_unit_nx      = r_u[0];
    assign o_unit_ny      = r_u[1];
    assign o_unit_nz      = r_u[2];
    assign o_plane_offset = r_off;
    assign o_degenerate   = r_deg;

endmodule

@@ bench/plane_from_points_test.sv @@
// Self-checking testbench for the normalized plane equation block.
`timescale 1ns / 1ps

module plane_from_points_test;
    import pfp_pkg::*;

    localparam int OP_THREE_POINTS = 0;
    localparam int OP_POINT_NORMAL = 1;
    localparam int IDLE_LIMIT      = 4000;
    localparam int DRAIN_CYCLES    = 120;

    // One input item and one plane result.
    typedef struct {
        logic                 op;
        logic signed [15:0]   p1 [3];
        logic signed [15:0]   p2 [3];
        logic signed [15:0]   p3 [3];
    } t_points;

    typedef struct {
        logic signed [15:0]   nx;
        logic signed [15:0]   ny;
        logic signed [15:0]   nz;
        logic signed [23:0]   offs;
        logic                 degen;
    } t_plane;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_op;
    logic signed [15:0]   i_p1_x, i_p1_y, i_p1_z;
    logic signed [15:0]   i_p2_x, i_p2_y, i_p2_z;
    logic signed [15:0]   i_p3_x, i_p3_y, i_p3_z;
    logic                 o_valid;
    logic                 i_stall;
    logic signed [15:0]   o_unit_nx, o_unit_ny, o_unit_nz;
    logic signed [23:0]   o_plane_offset;
    logic                 o_degenerate;

    t_points  pending_points [$];
    t_plane   expected_planes [$];
    int       error_count = 0;
    int       planes_checked = 0;
    int       degenerate_seen = 0;
    int       send_idle_pct;
    int       recv_idle_pct;
    bit       hold_sender;
    int       idle_cycles;

    plane_from_points u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_op(i_op),
        .i_p1_x(i_p1_x), .i_p1_y(i_p1_y), .i_p1_z(i_p1_z),
        .i_p2_x(i_p2_x), .i_p2_y(i_p2_y), .i_p2_z(i_p2_z),
        .i_p3_x(i_p3_x), .i_p3_y(i_p3_y), .i_p3_z(i_p3_z),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_unit_nx(o_unit_nx), .o_unit_ny(o_unit_ny), .o_unit_nz(o_unit_nz),
        .o_plane_offset(o_plane_offset), .o_degenerate(o_degenerate)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Integer square root, rounded down.
    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Signed quotient rounded to nearest, ties away from zero, then clamped.
    function automatic longint round_clamp(bit neg, longint unsigned mag,
                                           longint unsigned den, longint lim);
        longint unsigned q;
        longint v;
        q = (2 * mag + den) / (2 * den);
        v = neg ? -longint'(q) : longint'(q);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v;
    endfunction

    // Computes the normalized plane for one item.
    function automatic t_plane plane_of(t_points t);
        t_plane pl;
        longint a [3], b [3], nrm [3];
        longint unsigned mag [3];
        bit neg [3];
        longint unsigned top, sq, len, dmag;
        longint dot, dd;
        longint unit [3];
        pl = '{default: '0};
        if (t.op == OP_THREE_POINTS) begin
            for (int i = 0; i < 3; i++) begin
                a[i] = longint'(t.p2[i]) - longint'(t.p1[i]);
                b[i] = longint'(t.p3[i]) - longint'(t.p1[i]);
            end
            nrm[0] = a[1] * b[2] - a[2] * b[1];
            nrm[1] = a[2] * b[0] - a[0] * b[2];
            nrm[2] = a[0] * b[1] - a[1] * b[0];
        end else begin
            for (int i = 0; i < 3; i++) nrm[i] = longint'(t.p2[i]);
        end
        top = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = nrm[i] < 0;
            mag[i] = neg[i] ? longint'(-nrm[i]) : nrm[i];
            if (mag[i] > top) top = mag[i];
        end
        if (top == 0) begin
            pl.degen = 1'b1;
            return pl;
        end
        // Bring the largest magnitude into [2^19, 2^20).
        while (top >= (64'd1 << 20)) begin
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
            top >>= 1;
        end
        while (top < (64'd1 << 19)) begin
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
            top <<= 1;
        end
        sq = 0;
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            sq += mag[i] * mag[i];
            dot += (neg[i] ? -longint'(mag[i]) : longint'(mag[i])) * longint'(t.p1[i]);
        end
        len = isqrt(sq << 20);
        for (int i = 0; i < 3; i++)
            unit[i] = round_clamp(neg[i], mag[i] << 24, len, 16384);
        dd = -dot;
        dmag = dd < 0 ? longint'(-dd) : dd;
        pl.nx = unit[0][15:0];
        pl.ny = unit[1][15:0];
        pl.nz = unit[2][15:0];
        pl.offs = round_clamp(dd < 0, dmag << 16, len, 4194304) & 24'hFFFFFF;
        return pl;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 255)) - 16'd128;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_points rand_item();
        t_points t;
        t.op = 1'($urandom_range(0, 1));
        for (int i = 0; i < 3; i++) begin
            t.p1[i] = rand_coord();
            t.p2[i] = rand_coord();
            t.p3[i] = rand_coord();
        end
        // Collinear triples and zero normals now and then.
        if ($urandom_range(0, 19) == 0) begin
            for (int i = 0; i < 3; i++) begin
                t.p2[i] = (t.op == OP_POINT_NORMAL) ? 16'sd0 : t.p1[i];
            end
        end else if ($urandom_range(0, 19) == 0 && t.op == OP_THREE_POINTS) begin
            for (int i = 0; i < 3; i++) t.p3[i] = t.p2[i];
        end
        return t;
    endfunction

    function automatic t_points make_item(bit op, int x1, int y1, int z1,
                                          int x2, int y2, int z2,
                                          int x3, int y3, int z3);
        t_points t;
        t.op = op;
        t.p1 = '{16'(x1), 16'(y1), 16'(z1)};
        t.p2 = '{16'(x2), 16'(y2), 16'(z2)};
        t.p3 = '{16'(x3), 16'(y3), 16'(z3)};
        return t;
    endfunction

    // Driver: presents pending items, holds the payload while stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_op    <= 1'b0;
            i_p1_x <= '0; i_p1_y <= '0; i_p1_z <= '0;
            i_p2_x <= '0; i_p2_y <= '0; i_p2_z <= '0;
            i_p3_x <= '0; i_p3_y <= '0; i_p3_z <= '0;
        end else if (!i_valid || !o_stall) begin
            if (pending_points.size() != 0 && !hold_sender
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                t_points t;
                t = pending_points.pop_front();
                expected_planes.push_back(plane_of(t));
                i_valid <= 1'b1;
                i_op <= t.op;
                i_p1_x <= t.p1[0]; i_p1_y <= t.p1[1]; i_p1_z <= t.p1[2];
                i_p2_x <= t.p2[0]; i_p2_y <= t.p2[1]; i_p2_z <= t.p2[2];
                i_p3_x <= t.p3[0]; i_p3_y <= t.p3[1]; i_p3_z <= t.p3[2];
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Monitor: checks each result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_planes.size() == 0) begin
                $display("result transfer with no item outstanding");
                error_count++;
            end else begin
                t_plane w;
                w = expected_planes.pop_front();
                if (o_degenerate !== w.degen) report_mismatch("degenerate", o_degenerate, w.degen);
                if (o_unit_nx !== w.nx) report_mismatch("unit_nx", o_unit_nx, w.nx);
                if (o_unit_ny !== w.ny) report_mismatch("unit_ny", o_unit_ny, w.ny);
                if (o_unit_nz !== w.nz) report_mismatch("unit_nz", o_unit_nz, w.nz);
                if (o_plane_offset !== w.offs)
                    report_mismatch("plane_offset", o_plane_offset, w.offs);
                planes_checked++;
                if (w.degen) degenerate_seen++;
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (pending_points.size() == 0 && expected_planes.size() == 0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[plane_from_points] ERROR");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_points.size() != 0 || expected_planes.size() != 0 || i_valid)
            @(posedge i_clk);
    endtask

    // Stimulus and end of run.
    initial begin
        int drain;
        hold_sender = 0;
        send_idle_pct = 17; recv_idle_pct = 81;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items: axes, extremes, collinear and zero normals.
        pending_points.push_back(make_item(OP_THREE_POINTS, 0,0,0, 256,0,0, 0,256,0));
        pending_points.push_back(make_item(OP_THREE_POINTS, 0,0,256, 256,0,256, 0,256,256));
        pending_points.push_back(make_item(OP_THREE_POINTS, 5,5,5, 5,5,5, 5,5,5));
        pending_points.push_back(make_item(OP_THREE_POINTS, 0,0,0, 1,1,1, 2,2,2));
        pending_points.push_back(make_item(OP_THREE_POINTS,
            -32768,-32768,-32768, 32767,-32768,-32768, -32768,32767,32767));
        pending_points.push_back(make_item(OP_THREE_POINTS,
            32767,32767,32767, -32768,32767,-32768, 32767,-32768,-32768));
        pending_points.push_back(make_item(OP_THREE_POINTS,
            -32768,32767,0, 32767,-32768,32767, -32768,-32768,-32768));
        pending_points.push_back(make_item(OP_THREE_POINTS, 0,0,0, 1,0,0, 0,1,0));
        pending_points.push_back(make_item(OP_POINT_NORMAL, 100,-200,300, 0,0,0, 9,9,9));
        pending_points.push_back(make_item(OP_POINT_NORMAL, 256,0,0, 256,0,0, 0,0,0));
        pending_points.push_back(make_item(OP_POINT_NORMAL, 0,0,0, 0,0,1, 0,0,0));
        pending_points.push_back(make_item(OP_POINT_NORMAL,
            32767,32767,32767, 32767,32767,32767, -1,-1,-1));
        pending_points.push_back(make_item(OP_POINT_NORMAL,
            -32768,-32768,-32768, -32768,-32768,-32768, 32767,0,-32768));
        pending_points.push_back(make_item(OP_POINT_NORMAL,
            -32768,32767,-32768, -32768,0,0, 0,0,0));
        pending_points.push_back(make_item(OP_POINT_NORMAL, 1,2,3, 0,-32768,1, 0,0,0));
        pending_points.push_back(make_item(OP_POINT_NORMAL,
            32767,-32768,32767, 1,1,1, 0,0,0));
        wait_drained();

        // Random items, three idling phases; the sender holds off once mid-phase.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 81 : 0;
            recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 17 : 0;
            for (int k = 0; k < 580; k++) pending_points.push_back(rand_item());
            while (pending_points.size() > 290) @(posedge i_clk);
            hold_sender = 1'b1;
            while (expected_planes.size() != 0 || i_valid) @(posedge i_clk);
            hold_sender = 1'b0;
            wait_drained();
        end

        drain = 0;
        while (drain < DRAIN_CYCLES) begin
            @(posedge i_clk);
            drain++;
        end
        $display("Checked %0d planes (%0d degenerate) from both modes under three idle mixes.",
                 planes_checked, degenerate_seen);
        if (error_count == 0 && expected_planes.size() == 0) begin
            $display("[plane_from_points] OK");
        end else begin
            $display("[plane_from_points] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/pfp_pkg.sv
hdl/pfp_front.sv
hdl/pfp_fifo.sv
hdl/pfp_back.sv
hdl/plane_from_points.sv
bench/plane_from_points_test.sv
